/* hdl/gdbd_pkg.sv */
// gdbd_pkg: widths, stage records and calendar tables for the date difference pipeline
// no dependencies; used by gregorian_days_between_dates
package gdbd_pkg;

  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int PRIOR_W   = 15;   // year + 399 for years up to 16383
  localparam int QUART_W   = 13;   // value >> 2
  localparam int PROD_W    = 26;   // quarter * RECIP_25
  localparam int QUOT_W    = 9;    // quotient by 25
  localparam int DBM_W     = 9;
  localparam int DN_W      = 23;   // running day number, unsigned
  localparam int DIFF_W    = 24;
  localparam int OUT_W     = 23;

  // floor(x / 25) == (x * RECIP_25) >> RECIP_SH for x below 4196
  localparam logic [QUART_W-1:0] RECIP_25 = 13'd5243;
  localparam int                 RECIP_SH = 17;

  localparam logic [PRIOR_W-1:0] PRIOR_OFS = 15'd399;
  localparam logic [DN_W-1:0]    DAYS_YEAR = 23'd365;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic signed [DIFF_W-1:0] OUT_MAX = 24'sd4194303;
  localparam logic signed [DIFF_W-1:0] OUT_MIN = -24'sd4194304;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [3:0]         year_low;
    logic [QUART_W-1:0] year_quart;
    logic [PRIOR_W-1:0] prior;
    logic [PROD_W-1:0]  prod_year;
    logic [PROD_W-1:0]  prod_prior;
    logic [DBM_W-1:0]   dbm;
    logic [DAY_W-1:0]   mlen;
    logic               month_ok;
  } s1_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [DN_W-1:0]    base;
    logic [DBM_W-1:0]   dbm;
    logic [DAY_W-1:0]   mlen;
    logic               month_ok;
    logic               leap;
  } s2_t;

  typedef struct packed {
    logic [DN_W-1:0] dn;
    logic            ok;
  } s3_t;

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    days_before_month = 9'd0;
      4'd2:    days_before_month = 9'd31;
      4'd3:    days_before_month = 9'd59;
      4'd4:    days_before_month = 9'd90;
      4'd5:    days_before_month = 9'd120;
      4'd6:    days_before_month = 9'd151;
      4'd7:    days_before_month = 9'd181;
      4'd8:    days_before_month = 9'd212;
      4'd9:    days_before_month = 9'd243;
      4'd10:   days_before_month = 9'd273;
      4'd11:   days_before_month = 9'd304;
      4'd12:   days_before_month = 9'd334;
      default: days_before_month = 9'd0;
    endcase
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
    case (m)
      4'd2:                      month_length = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_length = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        month_length = 5'd31;
      default:                   month_length = 5'd0;
    endcase
  endfunction

endpackage

/* hdl/gregorian_days_between_dates.sv */
// gregorian_days_between_dates: signed day count between two gregorian dates
// depends on gdbd_pkg for widths, stage records and month tables
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid, in_stall  | first_day/month/year, second_day/month/year
//  out     | out_valid, out_stall| elapsed_days, date_error
//
// four register stages: reciprocal multiplies by 1/25, year sums and leap test,
// day number, then difference with saturation into the output register.
// one item per cycle while out_stall is low; each item passes s1, s2, s3 and the output register.
// rst clears the stage valid bits only; payload registers are not reset.
// out_stall with out_valid high freezes every stage at once; in_stall is high while the output
// register holds an item that is stalled.
module gregorian_days_between_dates (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         first_day,
  input  logic [3:0]         first_month,
  input  logic [13:0]        first_year,
  input  logic [4:0]         second_day,
  input  logic [3:0]         second_month,
  input  logic [13:0]        second_year,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] elapsed_days,
  output logic               date_error
);
  import gdbd_pkg::*;

  logic advance;
  logic v1, v2, v3;
  s1_t  s1 [2];
  s1_t  s1_next [2];
  s2_t  s2 [2];
  s2_t  s2_next [2];
  s3_t  s3 [2];
  s3_t  s3_next [2];
  logic signed [OUT_W-1:0] elapsed_next;
  logic                    error_next;

  logic [DAY_W-1:0]   in_day [2];
  logic [MONTH_W-1:0] in_month [2];
  logic [YEAR_W-1:0]  in_year [2];

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign in_day[0]   = first_day;
  assign in_month[0] = first_month;
  assign in_year[0]  = first_year;
  assign in_day[1]   = second_day;
  assign in_month[1] = second_month;
  assign in_year[1]  = second_year;

  // stage 1: month tables and the two products by the reciprocal of 25
  always_comb begin
    logic [PRIOR_W-1:0] prior;
    logic [QUART_W-1:0] yq;
    logic [QUART_W-1:0] pq;
    for (int i = 0; i < 2; i++) begin
      prior = {1'b0, in_year[i]} + PRIOR_OFS;
      yq    = QUART_W'(in_year[i][YEAR_W-1:2]);
      pq    = prior[PRIOR_W-1:2];
      s1_next[i].day        = in_day[i];
      s1_next[i].month      = in_month[i];
      s1_next[i].year_low   = in_year[i][3:0];
      s1_next[i].year_quart = yq;
      s1_next[i].prior      = prior;
      s1_next[i].prod_year  = PROD_W'(yq) * PROD_W'(RECIP_25);
      s1_next[i].prod_prior = PROD_W'(pq) * PROD_W'(RECIP_25);
      s1_next[i].dbm        = days_before_month(in_month[i]);
      s1_next[i].mlen       = month_length(in_month[i]);
      s1_next[i].month_ok   = (in_month[i] >= MONTH_JAN) && (in_month[i] <= MONTH_DEC);
    end
  end

  // stage 2: days of all prior years and the leap test
  always_comb begin
    logic [QUOT_W-1:0]  qy;
    logic [QUOT_W-1:0]  q100;
    logic [QUART_W-1:0] rem25;
    logic               cent;
    for (int i = 0; i < 2; i++) begin
      qy    = s1[i].prod_year[RECIP_SH +: QUOT_W];
      q100  = s1[i].prod_prior[RECIP_SH +: QUOT_W];
      rem25 = s1[i].year_quart - (QUART_W'(qy) * QUART_W'(25));
      // divisible by 100 when divisible by 4 and year/4 by 25; by 400 when also by 16
      cent  = (rem25 == '0);
      s2_next[i].day      = s1[i].day;
      s2_next[i].month    = s1[i].month;
      s2_next[i].dbm      = s1[i].dbm;
      s2_next[i].mlen     = s1[i].mlen;
      s2_next[i].month_ok = s1[i].month_ok;
      s2_next[i].leap     = (s1[i].year_low[1:0] == 2'b00) &&
                            (!cent || (s1[i].year_low == 4'b0000));
      s2_next[i].base     = DN_W'(s1[i].prior) * DAYS_YEAR
                            + DN_W'(s1[i].prior[PRIOR_W-1:2])
                            - DN_W'(q100)
                            + DN_W'(q100[QUOT_W-1:2]);
    end
  end

  // stage 3: running day number and date check
  always_comb begin
    logic [DAY_W-1:0] len;
    logic             feb_leap;
    for (int i = 0; i < 2; i++) begin
      feb_leap = s2[i].leap && (s2[i].month == MONTH_FEB);
      len      = s2[i].mlen + DAY_W'(feb_leap);
      s3_next[i].ok = s2[i].month_ok && (s2[i].day != '0) && (s2[i].day <= len);
      s3_next[i].dn = s2[i].base + DN_W'(s2[i].dbm) + DN_W'(s2[i].day)
                      + DN_W'(s2[i].leap && (s2[i].month > MONTH_FEB));
    end
  end

  // stage 4: difference, saturation, zero on error
  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    diff = $signed({1'b0, s3[1].dn}) - $signed({1'b0, s3[0].dn});
    if (diff > OUT_MAX) begin
      diff = OUT_MAX;
    end else if (diff < OUT_MIN) begin
      diff = OUT_MIN;
    end
    error_next = !(s3[0].ok && s3[1].ok);
    elapsed_next = error_next ? '0 : OUT_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1           <= s1_next;
      s2           <= s2_next;
      s3           <= s3_next;
      elapsed_days <= elapsed_next;
      date_error   <= error_next;
    end
  end

endmodule

/* tb/testbench.sv */
// testbench for gregorian_days_between_dates: date pairs in, signed day counts out
// depends on gdbd_pkg for field widths; self-checking against its own calendar arithmetic
// directed table first, then random pairs under four idle/stall mixes
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gdbd_pkg::*;

  localparam int LATENCY      = 4;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 880;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 60;

  localparam int unsigned CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                             304, 334};

  typedef struct packed {
    logic [DAY_W-1:0]   d1;
    logic [MONTH_W-1:0] m1;
    logic [YEAR_W-1:0]  y1;
    logic [DAY_W-1:0]   d2;
    logic [MONTH_W-1:0] m2;
    logic [YEAR_W-1:0]  y2;
  } date_pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] days;
    logic                    err;
  } gap_t;

  typedef struct {
    date_pair_t dates;
    bit         typed;
    gap_t       want;
  } vector_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [4:0]         first_day = '0;
  logic [3:0]         first_month = '0;
  logic [13:0]        first_year = '0;
  logic [4:0]         second_day = '0;
  logic [3:0]         second_month = '0;
  logic [13:0]        second_year = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [22:0] elapsed_days;
  logic               date_error;

  // what the sender is offering: a typed-in result or a predicted one
  bit   cur_typed = 1'b0;
  gap_t cur_want = '0;

  gap_t    pending_gaps[$];
  vector_t directed[$];
  int      mismatches = 0;
  int      items_in = 0;
  int      results_out = 0;
  int      invalid_results = 0;
  int      clipped_results = 0;
  int      quiet = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  int      hold_left = 0;
  bit      hold_toggle = 1'b0;
  bit      hold_seen = 1'b0;

  gregorian_days_between_dates dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_day    (first_day),
    .first_month  (first_month),
    .first_year   (first_year),
    .second_day   (second_day),
    .second_month (second_month),
    .second_year  (second_year),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .elapsed_days (elapsed_days),
    .date_error   (date_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit leap_year(input longint y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // zero for a month out of range, so any day fails against it
  function automatic int month_span(input logic [MONTH_W-1:0] m, input longint y);
    case (m)
      MONTH_FEB:                 return leap_year(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        return 31;
      default:                   return 0;
    endcase
  endfunction

  // days since a fixed epoch; year shifted by a 400-year cycle so year 0 counts
  function automatic longint day_index(input logic [DAY_W-1:0] d,
                                       input logic [MONTH_W-1:0] m,
                                       input logic [YEAR_W-1:0] y);
    longint yr;
    longint prior;
    longint n;
    yr    = longint'(y);
    prior = yr + 399;
    n     = prior * 365 + prior / 4 - prior / 100 + prior / 400;
    n     = n + CUM_DAYS[m - 1] + longint'(d);
    if (m > MONTH_FEB && leap_year(yr))
      n = n + 1;
    return n;
  endfunction

  function automatic gap_t predict_gap(input date_pair_t p);
    gap_t   g;
    longint diff;
    g = '0;
    if (p.d1 == 0 || p.d1 > month_span(p.m1, longint'(p.y1)) ||
        p.d2 == 0 || p.d2 > month_span(p.m2, longint'(p.y2))) begin
      g.err = 1'b1;
      return g;
    end
    diff = day_index(p.d2, p.m2, p.y2) - day_index(p.d1, p.m1, p.y1);
    if (diff > longint'(OUT_MAX))
      diff = longint'(OUT_MAX);
    if (diff < longint'(OUT_MIN))
      diff = longint'(OUT_MIN);
    g.days = diff[OUT_W-1:0];
    return g;
  endfunction

  // mostly ordinary years, some across the whole field, a few century and field edges
  function automatic logic [YEAR_W-1:0] pick_year();
    int r;
    r = $urandom_range(99);
    if (r < 80)
      return YEAR_W'($urandom_range(1, 9999));
    if (r < 93)
      return YEAR_W'($urandom_range(0, 16383));
    case ($urandom_range(5))
      0:       return 14'd0;
      1:       return 14'd16383;
      2:       return 14'd1600;
      3:       return 14'd1900;
      4:       return 14'd2000;
      default: return 14'd2100;
    endcase
  endfunction

  function automatic logic [MONTH_W-1:0] bad_month();
    return ($urandom_range(3) == 0) ? 4'd0 : MONTH_W'(12 + $urandom_range(1, 3));
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int         sel;
    int         span;
    sel = $urandom_range(99);
    if (sel < 8) begin
      p.d1 = DAY_W'($urandom);   p.m1 = MONTH_W'($urandom);  p.y1 = YEAR_W'($urandom);
      p.d2 = DAY_W'($urandom);   p.m2 = MONTH_W'($urandom);  p.y2 = YEAR_W'($urandom);
      return p;
    end
    p.y1 = pick_year();
    p.m1 = MONTH_W'($urandom_range(1, 12));
    p.d1 = DAY_W'($urandom_range(1, month_span(p.m1, longint'(p.y1))));
    if (sel < 35) begin
      // nearby second date: same or adjacent years
      if ($urandom_range(1) == 0)
        p.y2 = (p.y1 > 1) ? p.y1 - YEAR_W'($urandom_range(0, 1)) : p.y1;
      else
        p.y2 = (p.y1 < 16382) ? p.y1 + YEAR_W'($urandom_range(0, 1)) : p.y1;
    end else begin
      p.y2 = pick_year();
    end
    p.m2 = MONTH_W'($urandom_range(1, 12));
    span = month_span(p.m2, longint'(p.y2));
    p.d2 = DAY_W'($urandom_range(1, span));
    if (sel < 18) begin
      case ($urandom_range(3))
        0:       p.m1 = bad_month();
        1:       p.d1 = '0;
        2:       p.d2 = (span < 31) ? DAY_W'($urandom_range(span + 1, 31)) : '0;
        default: p.m2 = bad_month();
      endcase
    end
    return p;
  endfunction

  task automatic add_row(input int d1, input int m1, input int y1,
                         input int d2, input int m2, input int y2,
                         input bit typed, input int days, input bit err);
    vector_t v;
    v.dates.d1 = d1[DAY_W-1:0];
    v.dates.m1 = m1[MONTH_W-1:0];
    v.dates.y1 = y1[YEAR_W-1:0];
    v.dates.d2 = d2[DAY_W-1:0];
    v.dates.m2 = m2[MONTH_W-1:0];
    v.dates.y2 = y2[YEAR_W-1:0];
    v.typed     = typed;
    v.want.days = days[OUT_W-1:0];
    v.want.err  = err;
    directed.push_back(v);
  endtask

  task automatic send_pair(input date_pair_t p, input bit typed, input gap_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    first_day    <= p.d1;
    first_month  <= p.m1;
    first_year   <= p.y1;
    second_day   <= p.d2;
    second_month <= p.m2;
    second_year  <= p.y2;
    cur_typed    <= typed;
    cur_want     <= want;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_gaps.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic report_miss(input string what, input gap_t want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t %s: expected days %0d err %0b, got days %0d err %0b", $realtime, what,
               want.days, want.err, elapsed_days, date_error);
  endtask

  // results against the oldest expectation, then record the item taken this edge
  always @(posedge clk) begin : scoreboard
    gap_t want;
    gap_t fresh;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_out++;
        if (pending_gaps.size() == 0) begin
          report_miss("result with nothing pending", '0);
        end else begin
          want = pending_gaps.pop_front();
          if (want.err)
            invalid_results++;
          else if (want.days == OUT_MAX[OUT_W-1:0] || want.days == OUT_MIN[OUT_W-1:0])
            clipped_results++;
          if (elapsed_days !== want.days || date_error !== want.err)
            report_miss("mismatch", want);
        end
      end
      if (in_valid && !in_stall) begin
        fresh = cur_typed ? cur_want
                          : predict_gap({first_day, first_month, first_year,
                                         second_day, second_month, second_year});
        pending_gaps.push_back(fresh);
        items_in++;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 66, 0, 18};
    stall_mix = '{0, 0, 66, 18};

    //      d1  m1  y1     d2  m2  y2     typed days      err
    add_row( 1,  1,     1,  1,  1,     1, 1,        0, 0);  // same date
    add_row( 1,  1,     1, 31, 12,  9999, 1,  3652058, 0);  // span from year 1 to year 9999
    add_row(31, 12,  9999,  1,  1,     1, 1, -3652058, 0);
    add_row( 1,  1,     0, 31, 12, 16383, 1,  4194303, 0);  // clips high
    add_row(31, 12, 16383,  1,  1,     0, 1, -4194304, 0);  // clips low
    add_row(15,  0,  2000,  1,  1,  2000, 1,        0, 1);  // month zero
    add_row( 1,  1,  2000,  1, 13,  2000, 1,        0, 1);  // month past december
    add_row(31, 15, 16383,  1,  1,     1, 1,        0, 1);  // all-ones month
    add_row( 0,  6,  2010,  1,  1,  2010, 1,        0, 1);  // day zero
    add_row( 1,  1,  2010, 31,  4,  2010, 1,        0, 1);  // 31 april
    add_row(30,  2,  2000,  1,  1,  2000, 1,        0, 1);  // 30 feb
    add_row(29,  2,  2023,  1,  3,  2023, 1,        0, 1);  // 29 feb, common year
    add_row(29,  2,  1900,  1,  3,  1900, 1,        0, 1);  // 29 feb, century year
    add_row(31,  1,  2020,  0,  0,     0, 1,        0, 1);  // second date all zero
    add_row(28,  2,  1900,  1,  3,  1900, 0,        0, 0);
    add_row(28,  2,  2000,  1,  3,  2000, 0,        0, 0);
    add_row(29,  2,  2024,  1,  3,  2024, 0,        0, 0);
    add_row( 1,  1,     0,  1,  1,     1, 0,        0, 0);  // year zero is leap
    add_row(31, 12,  2099,  1,  1,  2100, 0,        0, 0);
    add_row( 1,  3,  1600, 28,  2,  2000, 0,        0, 0);
    add_row(31,  1,  2021,  1, 12,  2021, 0,        0, 0);
    add_row( 1,  1, 16383, 31, 12, 16383, 0,        0, 0);
    add_row(31, 12, 16383, 31, 12,     0, 0,        0, 0);

    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_pair(directed[i].dates, directed[i].typed, directed[i].want);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = idle_mix[ph];
      receiver_stall_pct = stall_mix[ph];
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        // long receiver hold-off while items keep coming, so the pipe backs up
        if (ph == 0 && k == 20)
          hold_toggle <= ~hold_toggle;
        send_pair(random_pair(), 1'b0, '0);
      end
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk);
    $display("covered %0d date pairs in four idle/stall mixes plus a long output hold-off;",
             items_in);
    $display("checked %0d results, %0d flagged invalid, %0d clipped to the output range",
             results_out, invalid_results, clipped_results);
    if (mismatches == 0 && pending_gaps.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures, %0d results still pending", mismatches, pending_gaps.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* gregorian_days_between_dates.f */
hdl/gdbd_pkg.sv
hdl/gregorian_days_between_dates.sv
tb/testbench.sv
